FILE: src/sha1_message_hasher_defines.svh
// Assertion macros used by the SHA-1 hasher controller.
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside of reset
`define SHA1MH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sha1 hasher: assertion failed");

// Antecedent in one cycle implies consequent in the next
`define SHA1MH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1 hasher: assertion failed");

`else

`define SHA1MH_ASSERT(lbl, clk, rst_n, prop)
`define SHA1MH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/sha1mh_pkg.sv
// Types, constants and round functions of the SHA-1 hasher.
package sha1mh_pkg;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_DONE
	} state_t;

	// Source of the byte shifted into the block buffer
	typedef enum logic [1:0] {
		BSEL_DATA,
		BSEL_PAD_ONE,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef logic [1:0] round_grp_t;
	typedef logic [6:0] round_cnt_t;

	localparam round_cnt_t ROUND_LAST    = 7'd79;
	localparam round_cnt_t ROUND_GRP_ONE = 7'd20;
	localparam round_cnt_t ROUND_GRP_TWO = 7'd40;
	localparam round_cnt_t ROUND_GRP_THR = 7'd60;

	localparam round_grp_t GRP_CH  = 2'd0;
	localparam round_grp_t GRP_P1  = 2'd1;
	localparam round_grp_t GRP_MAJ = 2'd2;
	localparam round_grp_t GRP_P2  = 2'd3;

	localparam logic [5:0] FILL_LEN_START = 6'd56;
	localparam logic [5:0] FILL_LAST      = 6'd63;
	localparam logic [7:0] PAD_BYTE       = 8'h80;

	// Initial chaining words, word 0 at index 0
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// Controller to datapath
	typedef struct packed {
		logic       shift_en;
		byte_sel_t  byte_sel;
		logic       count_inc;
		logic       load_len;
		logic       load_vars;
		logic       round_en;
		round_grp_t round_grp;
		logic       add_chain;
		logic       finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fill_last;
		logic fill_len;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] round_k(input round_grp_t grp);
		logic [31:0] k;
		case (grp)
			GRP_CH:  k = 32'h5A827999;
			GRP_P1:  k = 32'h6ED9EBA1;
			GRP_MAJ: k = 32'h8F1BBCDC;
			default: k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(input round_grp_t grp, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (grp)
			GRP_CH:  f = (b & c) | (~b & d);
			GRP_MAJ: f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

FILE: src/sha1mh_datapath.sv
// Block buffer, message schedule, round logic, chaining words and digest register.
module sha1mh_datapath import sha1mh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   data_byte,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic         m_tready,
	output logic         m_tvalid,
	output logic [159:0] m_tdata
);

	logic [511:0]      blk_q;
	logic [5:0]        fill_q;
	logic [60:0]       count_q;
	logic [63:0]       len_q;
	logic [4:0][31:0]  var_q;
	logic [4:0][31:0]  chain_q;
	logic [4:0][31:0]  digest_q;
	logic              valid_q;

	logic [7:0]  byte_in;
	logic [31:0] w_t;
	logic [31:0] w_mix;
	logic [31:0] w_new;
	logic [31:0] round_sum;

	// Byte source select
	always_comb begin
		case (cmd.byte_sel)
			BSEL_DATA:    byte_in = data_byte;
			BSEL_PAD_ONE: byte_in = PAD_BYTE;
			BSEL_ZERO:    byte_in = 8'h00;
			BSEL_LEN:     byte_in = len_q[63:56];
			default:      byte_in = 8'h00;
		endcase
	end

	// Schedule taps: w[t], w[t+2], w[t+8], w[t+13] of the sliding window
	assign w_t   = blk_q[511:480];
	assign w_mix = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
	assign w_new = {w_mix[30:0], w_mix[31]};

	// One SHA-1 round
	assign round_sum = {var_q[0][26:0], var_q[0][31:27]}
		+ round_f(cmd.round_grp, var_q[1], var_q[2], var_q[3])
		+ var_q[4] + round_k(cmd.round_grp) + w_t;

	// Block buffer as a byte shift line, reused as the schedule window
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// Length bytes, most significant first
	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			len_q <= {count_q, 3'b000};
		end else if (cmd.shift_en && cmd.byte_sel == BSEL_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Working variables a..e
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			var_q <= chain_q;
		end else if (cmd.round_en) begin
			var_q[4] <= var_q[3];
			var_q[3] <= var_q[2];
			var_q[2] <= {var_q[1][1:0], var_q[1][31:2]};
			var_q[1] <= var_q[0];
			var_q[0] <= round_sum;
		end
	end

	// Fill, byte count and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			chain_q <= H_INIT;
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.finish) begin
				count_q <= '0;
				chain_q <= H_INIT;
			end else begin
				if (cmd.count_inc) begin
					count_q <= count_q + 61'd1;
				end
				if (cmd.add_chain) begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
				end
			end
		end
	end

	// Digest output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			digest_q <= chain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.fill_last = (fill_q == FILL_LAST);
	assign sts.fill_len  = (fill_q == FILL_LEN_START);
	assign sts.out_free  = !valid_q || m_tready;

	assign m_tvalid = valid_q;
	assign m_tdata  = digest_q;

endmodule

FILE: src/sha1mh_ctrl.sv
// Controller: byte intake, padding sequence and compression round counter.
`include "sha1_message_hasher_defines.svh"

module sha1mh_ctrl import sha1mh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tuser,
	input  logic s_tlast,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	round_cnt_t rnd_q;

	// State and return-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// Round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cmd.load_vars) begin
			rnd_q <= '0;
		end else if (cmd.round_en) begin
			rnd_q <= rnd_q + 7'd1;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.byte_sel  = BSEL_DATA;
		if (rnd_q < ROUND_GRP_ONE) begin
			cmd.round_grp = GRP_CH;
		end else if (rnd_q < ROUND_GRP_TWO) begin
			cmd.round_grp = GRP_P1;
		end else if (rnd_q < ROUND_GRP_THR) begin
			cmd.round_grp = GRP_MAJ;
		end else begin
			cmd.round_grp = GRP_P2;
		end

		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						cmd.shift_en  = 1'b1;
						cmd.count_inc = 1'b1;
					end
					if (s_tuser && sts.fill_last) begin
						cmd.load_vars = 1'b1;
						state_d       = ST_ROUND;
						ret_d         = s_tlast ? ST_PAD_ONE : ST_IDLE;
					end else if (s_tlast) begin
						state_d = ST_PAD_ONE;
					end
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
				state_d       = ret_q;
			end
			ST_PAD_ONE: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = BSEL_PAD_ONE;
				cmd.load_len = 1'b1;
				state_d      = ST_PAD_ZERO;
				if (sts.fill_last) begin
					cmd.load_vars = 1'b1;
					state_d       = ST_ROUND;
					ret_d         = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (sts.fill_len) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.shift_en = 1'b1;
					cmd.byte_sel = BSEL_ZERO;
					if (sts.fill_last) begin
						cmd.load_vars = 1'b1;
						state_d       = ST_ROUND;
						ret_d         = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = BSEL_LEN;
				if (sts.fill_last) begin
					cmd.load_vars = 1'b1;
					state_d       = ST_ROUND;
					ret_d         = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Checks
	`SHA1MH_ASSERT(a_rnd_range, clk, arst_n, (state_q != ST_ROUND) || (rnd_q <= ROUND_LAST))
	`SHA1MH_ASSERT_NEXT(a_last_round_add, clk, arst_n,
		(state_q == ST_ROUND) && (rnd_q == ROUND_LAST), state_q == ST_ADD)
	`SHA1MH_ASSERT_NEXT(a_full_block_compress, clk, arst_n,
		(state_q == ST_IDLE) && s_tvalid && s_tuser && sts.fill_last,
		(state_q == ST_ROUND) && (rnd_q == '0))

endmodule

FILE: src/sha1_message_hasher.sv
// SHA-1 message hasher: top level joining controller and datapath.
//
// Input stream: one message byte per transaction on s_tdata, s_tuser set when the
// byte belongs to the message, s_tlast marking the final transaction of a message.
// A transaction with s_tuser low and s_tlast high ends a message without a byte.
// Output stream: one 160-bit digest transaction per message on m_tdata.
// Throughput: a byte is taken every cycle while the 64-byte block fills; each
// full block then runs the shared round unit for 80 rounds and then the chaining
// add, with s_tready low throughout. After the last transaction come the 0x80
// byte, zero bytes until 56 bytes are pending, a pause step, the bit length as
// eight bytes, the compression and the digest load; with 56 or more bytes
// pending, an extra block is compressed on the way.
// The digest sits in an output register: intake of the next message goes on
// while it waits; a stalled receiver only holds the finish step of the next one.
// Reset loads the standard initial chaining words and clears the byte count,
// the fill count and m_tvalid; no clearing pass is needed.
module sha1_message_hasher import sha1mh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] has_data
	input  logic         s_tlast,   // end_of_message
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata    // digest_word_0 [31:0] .. digest_word_4 [159:128]
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	sha1mh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Buffer, rounds and digest register
	sha1mh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
